>>> design/iso_date_string_validator_assert.svh
// Assertion macros shared by the date validator RTL.
// Each macro checks a property on the rising clock edge, held off during reset.
`ifndef ISO_DATE_STRING_VALIDATOR_ASSERT_SVH
`define ISO_DATE_STRING_VALIDATOR_ASSERT_SVH

// Checks an implication built by the caller on every clock edge.
`define IDSV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition holds whenever an enable is high.
`define IDSV_ASSERT_WHEN(label, en, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (en) |-> (cond)) \
		else $error(msg);

// Checks that a condition holds on the edge after a trigger.
`define IDSV_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

>>> design/idsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package idsv_pkg;

	localparam int CHAR_W = 8;
	localparam int ERR_W = 3;
	localparam int POS_W = 4;
	localparam int VAL2_W = 7;
	localparam int OUT_TDATA_W = 8;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [POS_W-1:0] POS_SAT = 4'd11;
	localparam logic [POS_W-1:0] DATE_LEN = 4'd10;
	localparam logic [POS_W-1:0] YEAR_LEN = 4'd4;
	localparam logic [POS_W-1:0] POS_SEP1 = 4'd4;
	localparam logic [POS_W-1:0] POS_MON0 = 4'd5;
	localparam logic [POS_W-1:0] POS_MON1 = 4'd6;
	localparam logic [POS_W-1:0] POS_SEP2 = 4'd7;
	localparam logic [POS_W-1:0] POS_DAY0 = 4'd8;
	localparam logic [POS_W-1:0] POS_DAY1 = 4'd9;

	localparam logic [CHAR_W-1:0] CHAR_DASH = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

	localparam logic [ERR_W-1:0] ERR_OK = 3'd0;
	localparam logic [ERR_W-1:0] ERR_LENGTH = 3'd1;
	localparam logic [ERR_W-1:0] ERR_SEP = 3'd2;
	localparam logic [ERR_W-1:0] ERR_DIGIT = 3'd3;
	localparam logic [ERR_W-1:0] ERR_MONTH = 3'd4;
	localparam logic [ERR_W-1:0] ERR_DAY = 3'd5;

	localparam logic [APB_ADDR_W-3:0] REG_ALLOW_YEAR_ONLY = 1'b0;
	localparam logic ALLOW_YEAR_ONLY_RST = 1'b1;

	// Days in a month for months 1 to 12; February is the common-year length.
	function automatic logic [4:0] month_days(input logic [3:0] month);
		logic [4:0] days;
		case (month)
			4'd2: days = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
			default: days = 5'd31;
		endcase
		return days;
	endfunction

	// One decimal digit step on a two-digit field.
	function automatic logic [VAL2_W-1:0] acc_digit(input logic [VAL2_W-1:0] v,
			input logic [3:0] d);
		logic [VAL2_W+3:0] sum;
		sum = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{VAL2_W{1'b0}}, d};
		return sum[VAL2_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> design/iso_date_string_validator.sv
`timescale 1ns / 1ps
`default_nettype none
// Date string checker. The string arrives on the s_axis channel one character
// per item (tdata = the ASCII byte, tlast = last character). Items without
// tlast give no result; the item with tlast gives one verdict item on m_axis
// (tdata bit 0 = valid_res, bits 3:1 = error_kind). Accepted forms are
// YYYY-MM-DD with a real Gregorian calendar date and, when register
// allow_year_only (APB address 0, bit 0) is 1, a bare four-digit year.
// A character is taken into an input register, then checked and accumulated
// from that register; the verdict is written to the output register when the
// last character leaves the input register, and stays there until m_axis_tready.
// One item per cycle is sustained in both directions; the only limit is the
// output register, so a stalled receiver stops the input only when a finished
// verdict and another last character are both waiting. Reset clears the
// string state and the output valid flag and sets allow_year_only to 1. The user
// must write configuration only while the block is idle; the block does not enforce it.
module iso_date_string_validator
	import idsv_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [CHAR_W-1:0] s_axis_tdata, // [7:0] char_code
	input wire logic s_axis_tlast,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata, // [0] valid_res, [3:1] error_kind, zero above
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [APB_ADDR_W-1:0] paddr,
	input wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic pready
);

	logic allow_year_only_q;
	logic valid_s1;
	logic last_s1;
	logic [CHAR_W-1:0] char_s1;

	logic [POS_W-1:0] pos_q;
	logic [VAL2_W-1:0] year_hi_q, year_lo_q, month_q, day_q;
	logic sep_bad_q, year_nd_q, rest_nd_q;

	logic out_valid_q;
	logic [ERR_W-1:0] err_q;

	logic out_free, s1_go, s1_adv;
	logic is_dig;
	logic [3:0] digit;
	logic [POS_W-1:0] pos_n;
	logic [VAL2_W-1:0] year_hi_n, year_lo_n, month_n, day_n;
	logic sep_bad_n, year_nd_n, rest_nd_n;
	logic leap;
	logic [4:0] max_day;
	logic [ERR_W-1:0] err_n;

	assign pready = 1'b1;
	assign prdata = (paddr[APB_ADDR_W-1:2] == REG_ALLOW_YEAR_ONLY)
		? {{(APB_DATA_W-1){1'b0}}, allow_year_only_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_year_only_q <= ALLOW_YEAR_ONLY_RST;
		end else if (psel && penable && pwrite && pready &&
				paddr[APB_ADDR_W-1:2] == REG_ALLOW_YEAR_ONLY) begin
			allow_year_only_q <= pwdata[0];
		end
	end

	// A non-final character never needs the output register.
	assign out_free = !out_valid_q || m_axis_tready;
	assign s1_go = !last_s1 || out_free;
	assign s1_adv = valid_s1 && s1_go;
	assign s_axis_tready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_comb begin
		is_dig = (char_s1 >= CHAR_ZERO) && (char_s1 <= CHAR_NINE);
		digit = is_dig ? char_s1[3:0] : 4'd0;
		year_hi_n = year_hi_q;
		year_lo_n = year_lo_q;
		month_n = month_q;
		day_n = day_q;
		sep_bad_n = sep_bad_q;
		year_nd_n = year_nd_q;
		rest_nd_n = rest_nd_q;
		if (pos_q < YEAR_LEN) begin
			if (!is_dig) begin
				year_nd_n = 1'b1;
			end else if (pos_q[1]) begin
				year_lo_n = acc_digit(year_lo_q, digit);
			end else begin
				year_hi_n = acc_digit(year_hi_q, digit);
			end
		end else if (pos_q == POS_SEP1 || pos_q == POS_SEP2) begin
			if (char_s1 != CHAR_DASH) begin
				sep_bad_n = 1'b1;
			end
		end else if (pos_q == POS_MON0 || pos_q == POS_MON1) begin
			if (is_dig) begin
				month_n = acc_digit(month_q, digit);
			end else begin
				rest_nd_n = 1'b1;
			end
		end else if (pos_q == POS_DAY0 || pos_q == POS_DAY1) begin
			if (is_dig) begin
				day_n = acc_digit(day_q, digit);
			end else begin
				rest_nd_n = 1'b1;
			end
		end
		pos_n = (pos_q < POS_SAT) ? pos_q + 4'd1 : pos_q;

		// With four good digits the year is 100*hi + lo, so the leap rules
		// reduce to checks on the low bits of the two halves.
		leap = (year_lo_n[1:0] == 2'b00) &&
			((year_lo_n != '0) || (year_hi_n[1:0] == 2'b00));
		max_day = (month_n == 7'd2 && leap) ? 5'd29 : month_days(month_n[3:0]);

		if (pos_n == YEAR_LEN && allow_year_only_q) begin
			err_n = year_nd_n ? ERR_DIGIT : ERR_OK;
		end else if (pos_n != DATE_LEN) begin
			err_n = ERR_LENGTH;
		end else if (sep_bad_n) begin
			err_n = ERR_SEP;
		end else if (year_nd_n || rest_nd_n) begin
			err_n = ERR_DIGIT;
		end else if (month_n < 7'd1 || month_n > 7'd12) begin
			err_n = ERR_MONTH;
		end else if (day_n < 7'd1 || day_n > {2'b00, max_day}) begin
			err_n = ERR_DAY;
		end else begin
			err_n = ERR_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			year_hi_q <= '0;
			year_lo_q <= '0;
			month_q <= '0;
			day_q <= '0;
			sep_bad_q <= 1'b0;
			year_nd_q <= 1'b0;
			rest_nd_q <= 1'b0;
		end else if (s1_adv) begin
			if (last_s1) begin
				pos_q <= '0;
				year_hi_q <= '0;
				year_lo_q <= '0;
				month_q <= '0;
				day_q <= '0;
				sep_bad_q <= 1'b0;
				year_nd_q <= 1'b0;
				rest_nd_q <= 1'b0;
			end else begin
				pos_q <= pos_n;
				year_hi_q <= year_hi_n;
				year_lo_q <= year_lo_n;
				month_q <= month_n;
				day_q <= day_n;
				sep_bad_q <= sep_bad_n;
				year_nd_q <= year_nd_n;
				rest_nd_q <= rest_nd_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			err_q <= err_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(OUT_TDATA_W-ERR_W-1){1'b0}}, err_q, err_q == ERR_OK};

`include "iso_date_string_validator_assert.svh"

	`IDSV_ASSERT_WHEN(a_code_range, m_axis_tvalid, m_axis_tdata[3:1] <= ERR_DAY, "error code out of range")
	`IDSV_ASSERT_NEXT(a_no_result_mid, valid_s1 && !last_s1 && !m_axis_tvalid, !m_axis_tvalid, "result from a non-final character")
	`IDSV_ASSERT_NEXT(a_clear_after_last, s1_adv && last_s1, pos_q == '0 && !sep_bad_q && !year_nd_q && !rest_nd_q, "string state not cleared after verdict")
	`IDSV_ASSERT(a_pos_sat, pos_q <= POS_SAT, "position count beyond saturation")

endmodule

`default_nettype wire

>>> bench/tb_iso_date_string_validator.sv
`timescale 1ns / 1ps

module tb_iso_date_string_validator;
	import idsv_pkg::*;

	localparam int YEAR_W = 14;
	localparam int LONG_HOLD = 80;
	localparam int DRAIN_CYCLES = 4;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic last;
	} char_item_t;

	typedef struct packed {
		logic ok;
		logic [ERR_W-1:0] kind;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [CHAR_W-1:0] s_axis_tdata = '0; // [7:0] char_code
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata; // [0] valid_res, [3:1] error_kind
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	iso_date_string_validator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	char_item_t char_q[$];
	verdict_t verdict_q[$];
	logic [CHAR_W-1:0] sbuf[$];

	// Mirror of the string state inside the block.
	bit allow_year = 1'b1;
	logic [POS_W-1:0] pos = '0;
	logic [YEAR_W-1:0] year_acc = '0;
	logic [VAL2_W-1:0] month_acc = '0;
	logic [VAL2_W-1:0] day_acc = '0;
	bit sep_bad = 1'b0;
	bit year_nondig = 1'b0;
	bit rest_nondig = 1'b0;

	int queued_n = 0;
	int accepted_n = 0;
	int strings_n = 0;
	int results_n = 0;
	int fail_n = 0;
	int kind_n[6] = '{default: 0};
	bit idle_on = 1'b1;
	int hold_requests = 0;
	int hold_served = 0;
	int tx_gap = 0;
	int rx_stall = 0;
	bit in_taken = 1'b0;
	int years_special[8] = '{0, 100, 400, 1900, 2000, 2023, 2024, 9999};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("[iso_date_string_validator] ERROR");
		$finish;
	end

	function automatic int month_len(int y, int m);
		int days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		bit leap;
		leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		if (m == 2 && leap)
			return 29;
		return days[m - 1];
	endfunction

	function automatic void absorb_char(logic [CHAR_W-1:0] c);
		bit dig;
		int d;
		int acc;
		dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		d = dig ? int'(c - CHAR_ZERO) : 0;
		if (pos < YEAR_LEN) begin
			if (dig) begin
				acc = int'(year_acc) * 10 + d;
				year_acc = acc[YEAR_W-1:0];
			end else begin
				year_nondig = 1'b1;
			end
		end else if (pos == POS_SEP1 || pos == POS_SEP2) begin
			if (c != CHAR_DASH)
				sep_bad = 1'b1;
		end else if (pos == POS_MON0 || pos == POS_MON1) begin
			if (dig) begin
				acc = int'(month_acc) * 10 + d;
				month_acc = acc[VAL2_W-1:0];
			end else begin
				rest_nondig = 1'b1;
			end
		end else if (pos == POS_DAY0 || pos == POS_DAY1) begin
			if (dig) begin
				acc = int'(day_acc) * 10 + d;
				day_acc = acc[VAL2_W-1:0];
			end else begin
				rest_nondig = 1'b1;
			end
		end
		if (pos < POS_SAT)
			pos = pos + 1'b1;
	endfunction

	// Verdict for the string collected so far; the string state starts over afterward.
	function automatic verdict_t judge_string();
		verdict_t v;
		logic [ERR_W-1:0] k;
		if (pos == YEAR_LEN && allow_year)
			k = year_nondig ? ERR_DIGIT : ERR_OK;
		else if (pos != DATE_LEN)
			k = ERR_LENGTH;
		else if (sep_bad)
			k = ERR_SEP;
		else if (year_nondig || rest_nondig)
			k = ERR_DIGIT;
		else if (month_acc < 1 || month_acc > 12)
			k = ERR_MONTH;
		else if (day_acc < 1 || int'(day_acc) > month_len(int'(year_acc), int'(month_acc)))
			k = ERR_DAY;
		else
			k = ERR_OK;
		v.ok = (k == ERR_OK);
		v.kind = k;
		pos = '0;
		year_acc = '0;
		month_acc = '0;
		day_acc = '0;
		sep_bad = 1'b0;
		year_nondig = 1'b0;
		rest_nondig = 1'b0;
		return v;
	endfunction

	always @(posedge clk) begin : monitor
		verdict_t want;
		in_taken = s_axis_tvalid && s_axis_tready;
		if (m_axis_tvalid && m_axis_tready) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: verdict with none expected: tdata=%h", $time, m_axis_tdata);
				fail_n++;
			end else begin
				want = verdict_q.pop_front();
				results_n++;
				if (m_axis_tdata[0] !== want.ok || m_axis_tdata[3:1] !== want.kind
						|| m_axis_tdata[OUT_TDATA_W-1:4] !== '0) begin
					$display("%0t: verdict mismatch: expected valid=%0b kind=%0d, got valid=%0b kind=%0d (tdata=%h)",
						$time, want.ok, want.kind, m_axis_tdata[0], m_axis_tdata[3:1], m_axis_tdata);
					fail_n++;
				end
			end
		end
		if (in_taken) begin
			accepted_n++;
			absorb_char(s_axis_tdata);
			if (s_axis_tlast) begin
				want = judge_string();
				verdict_q.push_back(want);
				kind_n[want.kind]++;
			end
		end
	end

	always @(negedge clk) begin : sender
		char_item_t item;
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (tx_gap == 0 && idle_on && $urandom_range(0, 9) == 0)
				tx_gap = $urandom_range(1, 10);
			if (tx_gap > 0 || char_q.size() == 0) begin
				if (tx_gap > 0)
					tx_gap--;
				s_axis_tvalid <= 1'b0;
			end else begin
				item = char_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= item.code;
				s_axis_tlast <= item.last;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			rx_stall = LONG_HOLD;
		end else if (rx_stall == 0 && idle_on && $urandom_range(0, 7) == 0) begin
			rx_stall = $urandom_range(1, 10);
		end
		if (rx_stall > 0) begin
			rx_stall--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	function automatic logic [CHAR_W-1:0] junk();
		case ($urandom_range(0, 3))
			0: return CHAR_DASH;
			1: return CHAR_ZERO + 8'($urandom_range(0, 9));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_digits(int v, int n);
		for (int i = n - 1; i >= 0; i--)
			sbuf.push_back(CHAR_ZERO + 8'((v / (10 ** i)) % 10));
	endtask

	task automatic push_date(int y, int m, int d);
		push_digits(y, 4);
		sbuf.push_back(CHAR_DASH);
		push_digits(m, 2);
		sbuf.push_back(CHAR_DASH);
		push_digits(d, 2);
	endtask

	task automatic send_string();
		foreach (sbuf[i])
			char_q.push_back(char_item_t'{sbuf[i], i == sbuf.size() - 1});
		queued_n += sbuf.size();
		strings_n++;
		sbuf.delete();
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			sbuf.push_back(s[i]);
		send_string();
	endtask

	// Random dates, some with bad month or day values; the rest are damaged, bare years or odd lengths.
	task automatic random_string();
		int pick;
		int y;
		int m;
		int d;
		pick = $urandom_range(0, 99);
		y = $urandom_range(0, 1) ? years_special[$urandom_range(0, 7)] : $urandom_range(0, 9999);
		m = $urandom_range(1, 12);
		d = $urandom_range(1, month_len(y, m));
		if (pick < 40) begin
			push_date(y, m, d);
		end else if (pick < 55) begin
			case ($urandom_range(0, 3))
				0: m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
				1: d = $urandom_range(0, 1) ? 0 : $urandom_range(month_len(y, m) + 1, 99);
				2: begin
					m = 2;
					d = 29;
				end
				default: begin
					m = 2;
					d = $urandom_range(28, 30);
				end
			endcase
			push_date(y, m, d);
		end else if (pick < 72) begin
			push_date(y, m, d);
			repeat ($urandom_range(1, 2))
				sbuf[$urandom_range(0, 9)] = junk();
		end else if (pick < 82) begin
			push_digits(y, 4);
			if ($urandom_range(0, 2) == 0)
				sbuf[$urandom_range(0, 3)] = junk();
		end else if (pick < 90) begin
			push_date(y, m, d);
			repeat ($urandom_range(1, 5))
				sbuf.push_back(junk());
		end else begin
			repeat ($urandom_range(1, 14))
				sbuf.push_back(junk());
		end
		send_string();
	endtask

	task automatic random_chars(int n);
		int goal;
		goal = queued_n + n;
		while (queued_n < goal)
			random_string();
	endtask

	// Waits until every character is taken and every verdict has come back.
	task automatic settle();
		@(negedge clk);
		while (accepted_n != queued_n || verdict_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apb_cycle(input logic wr, input logic [APB_DATA_W-1:0] wdata,
			output logic [APB_DATA_W-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {REG_ALLOW_YEAR_ONLY, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_year_only();
		logic [APB_DATA_W-1:0] rd;
		apb_cycle(1'b0, '0, rd);
		if (rd !== APB_DATA_W'(allow_year)) begin
			$display("%0t: allow_year_only readback: expected %h, got %h",
				$time, APB_DATA_W'(allow_year), rd);
			fail_n++;
		end
	endtask

	task automatic set_year_only(bit v);
		logic [APB_DATA_W-1:0] rd;
		apb_cycle(1'b1, APB_DATA_W'(v), rd);
		allow_year = v;
		check_year_only();
	endtask

	initial begin : stimulus
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		check_year_only();

		send_text("2000-02-29");
		send_text("9999");
		send_text("20x4");
		// A zero byte is just another non-digit, and a lone character is too short.
		sbuf.push_back(8'h00);
		send_string();
		sbuf.push_back(8'hFF);
		send_string();
		settle();

		set_year_only(1'b0);
		send_text("2023");
		random_chars(260);
		settle();

		// Receiver stalls while short strings pile up behind the output register.
		set_year_only(1'b1);
		hold_requests++;
		repeat (12) begin
			sbuf.push_back(junk());
			send_string();
		end
		random_chars(240);
		settle();

		set_year_only(1'b0);
		random_chars(200);
		settle();

		idle_on = 1'b0;
		set_year_only(1'b1);
		random_chars(200);
		settle();

		$display("Sent %0d strings (%0d characters) under both year-only settings; checked %0d verdicts.",
			strings_n, queued_n, results_n);
		$display("Verdicts by kind: ok %0d, length %0d, separator %0d, digit %0d, month %0d, day %0d.",
			kind_n[0], kind_n[1], kind_n[2], kind_n[3], kind_n[4], kind_n[5]);
		if (fail_n == 0)
			$display("[iso_date_string_validator] OK");
		else
			$display("[iso_date_string_validator] ERROR");
		$finish;
	end

endmodule
